>>> sv/rfd_pkg.sv
// rfd_pkg: shared types and codes for the fastcgi record deframer
// used by rfd_front, rfd_queue, rfd_back and fastcgi_record_deframer
// no dependencies
package rfd_pkg;

   localparam logic [1:0] KIND_STDOUT     = 2'd0;
   localparam logic [1:0] KIND_STDERR     = 2'd1;
   localparam logic [1:0] KIND_END        = 2'd2;
   localparam logic [1:0] KIND_UNHANDLED  = 2'd3;

   localparam logic [7:0] REC_END_REQUEST = 8'd3;
   localparam logic [7:0] REC_STDOUT      = 8'd6;
   localparam logic [7:0] REC_STDERR      = 8'd7;

   localparam logic [3:0] POS_LAST_HDR    = 4'd7;
   localparam logic [3:0] POS_BODY        = 4'd8;

   localparam int QUEUE_DEPTH_DEFAULT     = 4;

   typedef struct packed {
      logic [7:0]  data;
      logic [1:0]  kind;
      logic [7:0]  rtype;
      logic [15:0] reqnum;
      logic        last;
   } token_type;

   typedef struct packed {
      logic [3:0] hdr_pos;
      logic       done;
   } front_status_type;

endpackage

>>> sv/rfd_front.sv
// rfd_front: header gathering and classification of each stream byte
// emits one token per byte that yields a result; depends on rfd_pkg
module rfd_front
   import rfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_accept,
   input  logic             in_action,
   input  logic [7:0]       in_byte,
   output logic             tok_valid,
   output token_type        tok,
   output front_status_type status
);

   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] req_ff, req_in;
   logic [15:0] cl_ff, cl_in;
   logic [7:0]  pl_ff, pl_in;
   logic        done_ff, done_in;

   always_comb begin
      pos_in    = pos_ff;
      type_in   = type_ff;
      req_in    = req_ff;
      cl_in     = cl_ff;
      pl_in     = pl_ff;
      done_in   = done_ff;
      tok_valid = 1'b0;
      tok.data  = 8'd0;
      tok.kind  = KIND_UNHANDLED;
      tok.rtype = type_ff;
      tok.reqnum = req_ff;
      tok.last  = 1'b0;
      if (in_accept) begin
         if (in_action) begin
            pos_in  = 4'd0;
            type_in = 8'd0;
            req_in  = 16'd0;
            cl_in   = 16'd0;
            pl_in   = 8'd0;
            done_in = 1'b0;
         end else if (!done_ff) begin
            if (pos_ff < POS_BODY) begin
               case (pos_ff)
                  4'd1: type_in = in_byte;
                  4'd2: req_in = {in_byte, 8'd0};
                  4'd3: req_in = {req_ff[15:8], in_byte};
                  4'd4: cl_in = {in_byte, 8'd0};
                  4'd5: cl_in = {cl_ff[15:8], in_byte};
                  4'd6: pl_in = in_byte;
                  default: ;
               endcase
               if (pos_ff != POS_LAST_HDR) begin
                  pos_in = pos_ff + 4'd1;
               end else if (type_ff == REC_END_REQUEST) begin
                  done_in   = 1'b1;
                  pos_in    = 4'd0;
                  tok_valid = 1'b1;
                  tok.kind  = KIND_END;
               end else begin
                  pos_in = (cl_ff == 16'd0 && pl_ff == 8'd0) ? 4'd0 : POS_BODY;
                  if (type_ff != REC_STDOUT && type_ff != REC_STDERR) begin
                     tok_valid = 1'b1;
                     tok.kind  = KIND_UNHANDLED;
                  end
               end
            end else if (cl_ff != 16'd0) begin
               cl_in = cl_ff - 16'd1;
               if (cl_ff == 16'd1 && pl_ff == 8'd0) begin
                  pos_in = 4'd0;
               end
               tok.data = in_byte;
               tok.last = (cl_ff == 16'd1);
               if (type_ff == REC_STDOUT) begin
                  tok_valid = 1'b1;
                  tok.kind  = KIND_STDOUT;
               end else if (type_ff == REC_STDERR) begin
                  tok_valid = 1'b1;
                  tok.kind  = KIND_STDERR;
               end
            end else begin
               if (pl_ff != 8'd0) begin
                  pl_in = pl_ff - 8'd1;
               end
               if (pl_ff <= 8'd1) begin
                  pos_in = 4'd0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 4'd0;
         type_ff <= 8'd0;
         req_ff  <= 16'd0;
         cl_ff   <= 16'd0;
         pl_ff   <= 8'd0;
         done_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         type_ff <= type_in;
         req_ff  <= req_in;
         cl_ff   <= cl_in;
         pl_ff   <= pl_in;
         done_ff <= done_in;
      end
   end

   assign status.hdr_pos = pos_ff;
   assign status.done    = done_ff;

endmodule

>>> sv/rfd_queue.sv
// rfd_queue: token queue between front and back with a registered head
// memory array plus head register; depends on rfd_pkg
module rfd_queue
   import rfd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  token_type wr_data,
   output logic      full,
   output logic      head_valid,
   output token_type head_data,
   input  logic      head_take
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   token_type         mem [DEPTH];
   logic [AW-1:0]     wp_ff, wp_in;
   logic [AW-1:0]     rp_ff, rp_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              hv_ff, hv_in;
   token_type         head_ff;
   logic              rd_en;

   assign full  = (cnt_ff == CW'(DEPTH));
   assign rd_en = (!hv_ff || head_take) && (cnt_ff != '0);

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      hv_in  = hv_ff;
      if (wr_en) begin
         wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
      end
      if (rd_en) begin
         rp_in = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + AW'(1);
      end
      cnt_in = cnt_ff + CW'(wr_en) - CW'(rd_en);
      if (rd_en) begin
         hv_in = 1'b1;
      end else if (head_take) begin
         hv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
         hv_ff  <= 1'b0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
         hv_ff  <= hv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= wr_data;
      end
      if (rd_en) begin
         head_ff <= mem[rp_ff];
      end
   end

   assign head_valid = hv_ff;
   assign head_data  = head_ff;

endmodule

>>> sv/rfd_back.sv
// rfd_back: applies the stdout discard setting and holds the result register
// drains rfd_queue and drives the result channel; depends on rfd_pkg
module rfd_back
   import rfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       discard,
   input  logic       head_valid,
   input  token_type  head_data,
   output logic       head_take,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] out_byte,
   output logic [1:0] kind,
   output logic [7:0] record_type,
   output logic [15:0] request_number,
   output logic       last_of_record
);

   logic      ov_ff, ov_in;
   token_type out_ff;
   logic      drop;

   assign head_take = head_valid && (!ov_ff || pop);
   assign drop      = discard && (head_data.kind == KIND_STDOUT);

   always_comb begin
      ov_in = ov_ff;
      if (head_take) begin
         ov_in = !drop;
      end else if (pop) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_take && !drop) begin
         out_ff <= head_data;
      end
   end

   assign empty          = !ov_ff;
   assign out_byte       = out_ff.data;
   assign kind           = out_ff.kind;
   assign record_type    = out_ff.rtype;
   assign request_number = out_ff.reqnum;
   assign last_of_record = out_ff.last;

endmodule

>>> sv/fastcgi_record_deframer.sv
// fastcgi_record_deframer: top level of the fastcgi record deframer
// instantiates rfd_front, rfd_queue and rfd_back; depends on rfd_pkg
//
// Takes one byte of the backend response per cycle while full is low. push and
// full form the input queue interface; full only rises when results back up
// because pop is held low. A result passes through the queue memory write, the
// head register and then the result register before it is on the rsp_ ports,
// and a new result can be taken every cycle. Sustained rate is one byte per
// clock while full is low, handled by the header and body counters in the
// front parser. discard_stdout is written through csr_wr_en/csr_wr_data; the
// user must write it only while idle, which the block itself does not enforce.
module fastcgi_record_deframer
   import rfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_record_type,
   output logic [15:0] rsp_request_number,
   output logic        rsp_last_of_record,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic             discard_ff, discard_in;
   logic             accept;
   logic             tok_valid;
   token_type        tok;
   front_status_type fstat;
   logic             head_valid;
   token_type        head_data;
   logic             head_take;

   assign accept     = push && !full;
   assign discard_in = csr_wr_en ? csr_wr_data : discard_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         discard_ff <= 1'b0;
      end else begin
         discard_ff <= discard_in;
      end
   end

   rfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_action (req_action),
      .in_byte   (req_data_byte),
      .tok_valid (tok_valid),
      .tok       (tok),
      .status    (fstat)
   );

   rfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (tok_valid),
      .wr_data    (tok),
      .full       (full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_take  (head_take)
   );

   rfd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .discard        (discard_ff),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .head_take      (head_take),
      .empty          (empty),
      .pop            (pop),
      .out_byte       (rsp_out_byte),
      .kind           (rsp_kind),
      .record_type    (rsp_record_type),
      .request_number (rsp_request_number),
      .last_of_record (rsp_last_of_record)
   );

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action) |=> (fstat.hdr_pos == 4'd0 && !fstat.done))
      else $error("restart did not clear parser state");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      fstat.hdr_pos <= POS_BODY)
      else $error("header position out of range");

   a_done_at_header: assert property (@(posedge clock) disable iff (reset)
      fstat.done |-> (fstat.hdr_pos == 4'd0))
      else $error("parser stopped outside header position zero");

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (fstat.done && accept && !req_action) |-> !tok_valid)
      else $error("token produced after end of request");

endmodule
